/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* hdl/i2rd_pkg.sv */
// ----------------------------------------------------------------------------
// i2rd_pkg
// constants and digit encoding for the integer to radix digits converter
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int unsigned VALUE_W            = 64;  // input field width
  localparam int unsigned VALUE_BITS_DEFAULT = 64;
  localparam int unsigned RADIX_W            = 6;
  localparam int unsigned DIGIT_W            = 6;   // digit value 0..35
  localparam int unsigned CHAR_W             = 7;
  localparam int unsigned STEP_BITS          = 8;   // dividend bits per cycle
  localparam int unsigned CFG_IDX_W          = 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

  // digit value to ascii, letters for ten and up
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CHAR_ZERO + CHAR_W'(d);
    end else if (upper) begin
      ch = CHAR_UPPER + CHAR_W'(d - DIGIT_TEN);
    end else begin
      ch = CHAR_LOWER + CHAR_W'(d - DIGIT_TEN);
    end
    return ch;
  endfunction

endpackage

/* hdl/integer_to_radix_digits_top.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// converts a signed integer into ascii digits of radix 2..36, msd first
// ----------------------------------------------------------------------------
// each digit runs through the divider chunk by chunk, STEP dividend bits at a time; a further
//   ST_DIV pass spots the zero quotient, then digits load one per ready cycle
// one value at a time, through the single 8-bit-per-cycle divider; radix 2 on
//   the most negative 64-bit value is the longest run
// an out-of-range radix loads its single error result from ST_ERR once the output is free
// reset: async active low, radix returns to 10 and upper case to 0, idle

`include "assert_macros.svh"

module integer_to_radix_digits_top #(
  parameter int unsigned VALUE_BITS = i2rd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [i2rd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [i2rd_pkg::RADIX_W-1:0]    cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [i2rd_pkg::VALUE_W-1:0]    s_axis_tdata_i,   // [63:0] value
  // output stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,   // [6:0] digit_char, [7] zero
  output logic                            m_axis_tlast_o,   // last_digit
  output logic [1:0]                      m_axis_tuser_o    // [0] is_negative, [1] bad_radix
);

  localparam int unsigned STEP   = i2rd_pkg::STEP_BITS;
  localparam int unsigned WIDE   = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int unsigned CHUNKS = WIDE / STEP;
  localparam int unsigned CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned NUM_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned DW     = i2rd_pkg::DIGIT_W;
  localparam int unsigned CW     = i2rd_pkg::CHAR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_e;

  // configuration registers
  logic [i2rd_pkg::RADIX_W-1:0] radix_q;
  logic                         upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= i2rd_pkg::RADIX_RESET;
      upper_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2rd_pkg::REG_RADIX:      radix_q <= cfg_data_i;
        i2rd_pkg::REG_UPPER_CASE: upper_q <= cfg_data_i[0];
        default:                  ;
      endcase
    end
  end

  state_e             state_q;
  logic [WIDE-1:0]    quo_q;       // dividend shifting out, quotient shifting in
  logic [DW-1:0]      rem_q;
  logic [CNT_W-1:0]   cnt_q;       // chunk within the current digit
  logic [NUM_W-1:0]   num_q;       // digits held in the stack
  logic               neg_q;
  logic [DW-1:0]      stack_q [VALUE_BITS];  // digit lifo, top at entry 0

  logic               m_valid_q;
  logic [CW-1:0]      m_char_q;
  logic               m_last_q;
  logic               m_neg_q;
  logic               m_bad_q;

  // input side
  logic                   accept;
  logic [VALUE_BITS-1:0]  in_val;
  logic                   in_neg;
  logic [VALUE_BITS-1:0]  in_mag;
  logic                   radix_ok;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_val          = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_neg          = in_val[VALUE_BITS-1];
  assign in_mag          = in_neg ? (~in_val + 1'b1) : in_val;
  assign radix_ok        = (radix_q >= i2rd_pkg::RADIX_MIN) &&
                           (radix_q <= i2rd_pkg::RADIX_MAX);

  // shared divider: STEP restoring steps of the remainder against the radix
  logic [WIDE-1:0] quo_d;
  logic [DW-1:0]   rem_d;

  always_comb begin
    logic [DW:0] trial;
    rem_d = (cnt_q == '0) ? '0 : rem_q;
    quo_d = quo_q;
    for (int i = 0; i < STEP; i++) begin
      trial = {rem_d, quo_d[WIDE-1]};
      quo_d = {quo_d[WIDE-2:0], 1'b0};
      if (trial >= (DW+1)'(radix_q)) begin
        trial    = trial - (DW+1)'(radix_q);
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DW-1:0];
    end
  end

  // sequencer decisions
  logic out_free;
  logic div_done;   // quotient ran to zero after at least one digit
  logic last_chunk;
  logic push;
  logic pop;

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign div_done   = (cnt_q == '0) && (num_q != '0) && (quo_q == '0);
  assign last_chunk = (cnt_q == CNT_W'(CHUNKS - 1));
  assign push       = (state_q == ST_DIV) && !div_done && last_chunk;
  assign pop        = (state_q == ST_EMIT) && out_free;

  // digit stack, a shift line with the top at entry 0
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int i = VALUE_BITS - 1; i > 0; i--) begin
        stack_q[i] <= stack_q[i-1];
      end
      stack_q[0] <= rem_d;
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      quo_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      num_q     <= '0;
      neg_q     <= 1'b0;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
      m_neg_q   <= 1'b0;
      m_bad_q   <= 1'b0;
    end else begin
      // output register empties once taken, reloaded below if there is more
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            quo_q   <= WIDE'(in_mag);
            cnt_q   <= '0;
            num_q   <= '0;
            neg_q   <= in_neg;
            state_q <= radix_ok ? ST_DIV : ST_ERR;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EMIT;
          end else begin
            quo_q <= quo_d;
            rem_q <= rem_d;
            if (last_chunk) begin
              cnt_q <= '0;
              num_q <= num_q + 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= i2rd_pkg::digit_to_ascii(stack_q[0], upper_q);
            m_last_q  <= (num_q == NUM_W'(1));
            m_neg_q   <= neg_q;
            m_bad_q   <= 1'b0;
            num_q     <= num_q - 1'b1;
            if (num_q == NUM_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_char_q  <= '0;
            m_last_q  <= 1'b1;
            m_neg_q   <= 1'b0;
            m_bad_q   <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = {m_bad_q, m_neg_q};

  // a digit leaving the stack needs one to be there
  `ASSERT_NEVER(a_emit_nonempty, (state_q == ST_EMIT) && (num_q == '0),
                "emit state with an empty digit stack")
  // an error result is a single zero transfer
  `ASSERT_PROP(a_err_single, m_valid_q && m_bad_q |-> m_last_q && (m_char_q == '0),
               "error result not marked last or carries a character")
  // the stack never grows past the longest run
  `ASSERT_NEVER(a_stack_bound, push && (num_q == NUM_W'(VALUE_BITS)),
                "digit stack overflow")
  // a completed digit run leaves the block idle with no digits pending
  `ASSERT_PROP(a_run_drained,
               $past(state_q == ST_EMIT) && (state_q == ST_IDLE) |-> (num_q == '0),
               "digits left over after the last transfer")

endmodule

/* dv/tb_integer_to_radix_digits_top.sv */
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_top
// checks the radix digit converter against a digit predictor of its own:
// every accepted value is expanded into its expected digit transfers, and
// each digit transfer is compared field by field with the oldest one waiting
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_top;
  import i2rd_pkg::*;

  localparam int unsigned VALUE_BITS   = VALUE_BITS_DEFAULT;
  localparam int unsigned LIMIT_CYCLES = 4000000;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii;
    logic              negative;
    logic              last;
    logic              bad;
  } digit_result_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 drain;  // hold off until every digit is back
  } value_item_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port, driven by the stimulus process only
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = REG_RADIX;
  logic [RADIX_W-1:0]   cfg_data = '0;

  // value stream, driven by the sender
  logic               value_valid = 1'b0;
  logic [VALUE_W-1:0] value_data  = '0;
  logic               value_taken = 1'b0;  // transfer seen at the last rising edge
  int                 send_gap    = 0;

  // digit stream, ready driven by the receiver
  logic digit_ready = 1'b0;
  int   stall_left  = 0;

  // dut outputs
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;

  // predictor copy of the two registers
  logic [RADIX_W-1:0] radix_mirror = RADIX_RESET;
  logic               upper_mirror = 1'b0;

  value_item_t   pending_values[$];
  digit_result_t expected_digits[$];

  bit calm = 1'b0;  // no idling on either side while set

  int mismatch_count  = 0;
  int values_sent     = 0;
  int digits_checked  = 0;
  int values_finished = 0;
  int bad_replies     = 0;
  int mode_changes    = 0;
  int cycle_count     = 0;

  integer_to_radix_digits_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(value_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (value_data),       // [63:0] value
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(digit_ready),
    .m_axis_tdata_o (m_axis_tdata_o),   // [6:0] digit_char, [7] zero
    .m_axis_tlast_o (m_axis_tlast_o),   // last_digit
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] is_negative, [1] bad_radix
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones, none at all while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d,
                                                 input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? CHAR_UPPER : CHAR_LOWER;
    // decimal digits map straight onto '0'..'9', the rest onto letters
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return letter_base + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // expands one accepted value into the digit transfers it must cause
  task automatic predict_digits(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic [DIGIT_W-1:0] msd_first[$];
    digit_result_t      res;
    mask = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
    v    = raw & mask;
    neg  = v[VALUE_BITS-1];
    // magnitude of the most negative value still fits as unsigned
    mag  = neg ? ((~v + 1'b1) & mask) : v;
    values_sent++;
    if (radix_mirror < RADIX_MIN || radix_mirror > RADIX_MAX) begin
      res = '{ascii: '0, negative: 1'b0, last: 1'b1, bad: 1'b1};
      expected_digits.push_back(res);
      return;
    end
    do begin
      msd_first.push_front(DIGIT_W'(mag % radix_mirror));
      mag = mag / radix_mirror;
    end while (mag != 0);
    foreach (msd_first[k]) begin
      res.ascii    = ascii_of(msd_first[k], upper_mirror);
      res.negative = neg;
      res.last     = (k == msd_first.size() - 1);
      res.bad      = 1'b0;
      expected_digits.push_back(res);
    end
  endtask

  task automatic check_digit();
    digit_result_t want;
    if (expected_digits.size() == 0) begin
      report_mismatch($sformatf("digit transfer with nothing expected, tdata %h",
                                m_axis_tdata_o));
      return;
    end
    want = expected_digits.pop_front();
    if (m_axis_tdata_o !== {1'b0, want.ascii}) begin
      report_mismatch($sformatf("digit_char %h, expected %h", m_axis_tdata_o, want.ascii));
    end
    if (m_axis_tuser_o[0] !== want.negative) begin
      report_mismatch($sformatf("is_negative %b, expected %b", m_axis_tuser_o[0],
                                want.negative));
    end
    if (m_axis_tlast_o !== want.last) begin
      report_mismatch($sformatf("last_digit %b, expected %b", m_axis_tlast_o, want.last));
    end
    if (m_axis_tuser_o[1] !== want.bad) begin
      report_mismatch($sformatf("bad_radix %b, expected %b", m_axis_tuser_o[1], want.bad));
    end
    digits_checked++;
    if (want.last) values_finished++;
    if (want.bad) bad_replies++;
  endtask

  // sender: presents queued values at the falling edge, holds until transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      value_valid <= 1'b0;
      send_gap    <= 0;
    end else if (value_valid && !value_taken) begin
      // waiting for the transfer
    end else if (send_gap != 0) begin
      value_valid <= 1'b0;
      send_gap    <= send_gap - 1;
    end else if (pending_values.size() != 0 &&
                 !(pending_values[0].drain && expected_digits.size() != 0)) begin
      value_valid <= 1'b1;
      value_data  <= pending_values[0].value;
      void'(pending_values.pop_front());
      send_gap    <= pick_gap();
      // now and then switch between idling and running flat out
      if ($urandom_range(0, 15) == 0) calm <= !calm;
    end else begin
      value_valid <= 1'b0;
    end
  end

  // receiver: random stalls on the digit stream
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      digit_ready <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      digit_ready <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      digit_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // monitor: samples both streams and the register writes at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      radix_mirror <= RADIX_RESET;
      upper_mirror <= 1'b0;
      value_taken  <= 1'b0;
    end else begin
      value_taken <= value_valid && s_axis_tready_o;
      // check before predicting, so a stray digit cannot match a fresh value
      if (m_axis_tvalid_o && digit_ready) check_digit();
      if (value_valid && s_axis_tready_o) predict_digits(value_data);
      if (cfg_we) begin
        case (cfg_idx)
          REG_RADIX:      radix_mirror <= cfg_data;
          REG_UPPER_CASE: upper_mirror <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout: %0d digits still expected, %0d values queued",
               expected_digits.size(), pending_values.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic wait_idle();
    while (pending_values.size() != 0 || value_valid || expected_digits.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // registers change only with nothing in flight
  task automatic set_mode(input logic [RADIX_W-1:0] r, input logic u);
    wait_idle();
    repeat (4) @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_RADIX;
    cfg_data <= r;
    @(negedge clk_i);
    cfg_idx  <= REG_UPPER_CASE;
    cfg_data <= RADIX_W'(u);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    mode_changes++;
  endtask

  task automatic queue_value(input logic [VALUE_W-1:0] v, input bit drain);
    value_item_t it;
    it.value = v;
    it.drain = drain;
    pending_values.push_back(it);
  endtask

  function automatic logic [VALUE_W-1:0] random_value(input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] p;
    int                 k;
    case ($urandom_range(0, 7))
      0, 1, 2: return {$urandom, $urandom};
      3:       return VALUE_W'($urandom_range(0, 1000));
      4:       return -VALUE_W'($urandom_range(1, 1000));
      5: begin
        // around a power of the radix, where the digit count steps
        p = 1;
        k = $urandom_range(1, 64);
        if (r >= RADIX_MIN) begin
          repeat (k) begin
            if (p <= 64'h7FFF_FFFF_FFFF_FFFF / r) p = p * r;
          end
        end
        case ($urandom_range(0, 2))
          0:       return p - 1;
          1:       return p;
          default: return -p;
        endcase
      end
      6: begin
        case ($urandom_range(0, 3))
          0:       return 64'h8000_0000_0000_0000;
          1:       return 64'h7FFF_FFFF_FFFF_FFFF;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: begin
        p = {$urandom, $urandom} >> $urandom_range(0, 63);
        return $urandom_range(0, 1) ? -p : p;
      end
    endcase
  endfunction

  initial begin
    logic [RADIX_W-1:0] r;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: radix ten, lower case
    queue_value(64'd0, 1'b0);
    queue_value(64'd1, 1'b0);
    queue_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b0);
    queue_value(64'd9, 1'b0);
    queue_value(64'd10, 1'b0);
    queue_value(-64'd12345, 1'b0);

    // binary: most negative value gives the longest run
    set_mode(RADIX_MIN, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_value(64'h5555_5555_5555_5555, 1'b0);
    queue_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

    // highest radix with capital letters
    set_mode(RADIX_MAX, 1'b1);
    queue_value(64'h8000_0000_0000_0000, 1'b0);
    queue_value(64'd35, 1'b0);
    queue_value(64'd36, 1'b0);
    queue_value(-64'd35, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);

    // hex, lower case letters
    set_mode(6'd16, 1'b0);
    queue_value(64'hDEAD_BEEF_CAFE_F00D, 1'b0);
    queue_value(64'h0123_4567_89AB_CDEF, 1'b0);

    // out of range radix on both sides, including all-ones
    set_mode(6'd0, 1'b1);
    queue_value(-64'd5, 1'b0);
    set_mode(6'd1, 1'b0);
    queue_value(64'd42, 1'b0);
    set_mode(6'd37, 1'b0);
    queue_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    set_mode(6'd63, 1'b1);
    queue_value(64'h8000_0000_0000_0000, 1'b0);

    // random phases, mostly valid radices
    for (int ph = 0; ph < 8; ph++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                 : RADIX_W'($urandom_range(37, 63));
      end else begin
        r = RADIX_W'($urandom_range(2, 36));
      end
      set_mode(r, 1'($urandom_range(0, 1)));
      for (int i = 0; i < 17; i++) begin
        // one forced drain pause, plus a few random ones
        queue_value(random_value(r), (ph == 3 && i == 10) || $urandom_range(0, 24) == 0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("covered %0d values in %0d register settings: %0d digit transfers, %0d bad radix",
             values_sent, mode_changes + 1, digits_checked, bad_replies);
    $display("%0d runs ended with last_digit, %0d mismatches", values_finished,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
